// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the top level rtl file of the decomposition core
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ATRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every rising clock edge, reset included
`define ATRS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/atrs_pkg.sv -----
// types and constants of the affine matrix to trs decomposition core
// no dependencies; imported by every module of the core
package atrs_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SCALE_W = 31;
    localparam int unsigned NUM_W   = 34;   // divider numerator, signed
    localparam int unsigned DEN_W   = 33;   // divider denominator, unsigned
    localparam int unsigned QUO_W   = 31;   // raw quotient bits
    localparam int unsigned IN_W    = 384;
    localparam int unsigned OUT_W   = 320;

    localparam int unsigned SQRT_LAT  = 32;
    localparam int unsigned DIV_LAT   = QUO_W + 2;
    localparam int unsigned LANE_LAT  = 2 + SQRT_LAT + DIV_LAT;
    localparam int unsigned MERGE_LAT = 3 + SQRT_LAT + DIV_LAT;
    localparam int unsigned CORE_LAT  = LANE_LAT + MERGE_LAT;

    localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh4000_0000;

    // branch of the trace method, named after the diagonal component
    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_X = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic                zero;
        logic [SCALE_W-1:0]  scale;
        logic [WORD_W-1:0]   r2;
        logic [WORD_W-1:0]   r1;
        logic [WORD_W-1:0]   r0;
    } lane_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] x;
    } quat_t;

endpackage

// ----- hw/rtl/affine_matrix_to_trs_core.sv -----
// top level of the affine matrix to translation, rotation and scale core
// uses atrs_pkg, atrs_lane, atrs_merge, atrs_delay and assert_macros.svh
//
// Splits a column-major affine 4x4 matrix without shear (three basis columns
// and a translation, signed Q16.16) into the translation, three column
// lengths as scales and a unit quaternion in Q2.30. The core takes one
// transfer per clock while s_tready is high. The result is computed by
// two bit-per-stage passes: per column a 32-stage square root and
// 33-stage dividers in three parallel lanes, then a merging stage with
// trace method branch choice, a second 32-stage root and three more
// dividers. A two-entry output buffer lets the pipeline keep taking
// transfers while a result waits; s_tready drops only when both entries
// hold results. A matrix with any all-zero column gives the identity
// quaternion (0,0,0,1.0). No state is kept from one transfer to the
// next.
`include "assert_macros.svh"

module affine_matrix_to_trs_core
    import atrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z, zaxis_x, zaxis_y,
    // zaxis_z, move_x, move_y, move_z, 32 bits each from bit 0 up
    input  logic [IN_W-1:0]  s_tdata,

    output logic             m_tvalid,
    input  logic             m_tready,
    // out_move_x, out_move_y, out_move_z, quat_x, quat_y, quat_z, quat_w
    // (32 bits each), scale_x, scale_y, scale_z (31 bits each), 3 zero bits
    output logic [OUT_W-1:0] m_tdata
);

    // pipeline advances whenever the output buffer has room
    logic       en;
    logic [1:0] cnt_reg;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    // valid bits travel alongside the payload
    logic valid_reg [CORE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(CORE_LAT); i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < int'(CORE_LAT); i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // column lanes, one per basis vector
    lane_out_t lane_out [3];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        atrs_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .col_x    ($signed(s_tdata[(3*c+0)*WORD_W +: WORD_W])),
            .col_y    ($signed(s_tdata[(3*c+1)*WORD_W +: WORD_W])),
            .col_z    ($signed(s_tdata[(3*c+2)*WORD_W +: WORD_W])),
            .lane_out (lane_out[c])
        );
    end

    quat_t quat;

    atrs_merge u_merge (
        .aclk   (aclk),
        .en     (en),
        .lane_x (lane_out[0]),
        .lane_y (lane_out[1]),
        .lane_z (lane_out[2]),
        .quat   (quat)
    );

    // translation rides along untouched
    logic [3*WORD_W-1:0] move_d;

    atrs_delay #(.W(3 * WORD_W), .D(CORE_LAT)) u_move_dly (
        .aclk (aclk),
        .en   (en),
        .din  (s_tdata[9*WORD_W +: 3*WORD_W]),
        .dout (move_d)
    );

    // scales leave the lanes early and wait out the merging stage
    logic [3*SCALE_W-1:0] scale_d;

    atrs_delay #(.W(3 * SCALE_W), .D(MERGE_LAT)) u_scale_dly (
        .aclk (aclk),
        .en   (en),
        .din  ({lane_out[2].scale, lane_out[1].scale, lane_out[0].scale}),
        .dout (scale_d)
    );

    logic             tail_valid;
    logic [OUT_W-1:0] tail_data;

    assign tail_valid = valid_reg[CORE_LAT-1];
    assign tail_data  = {3'b000, scale_d, quat.w, quat.z, quat.y, quat.x, move_d};

    // two-entry output buffer, slot0 is the head
    logic             push, pop;
    logic [OUT_W-1:0] slot0_reg, slot1_reg;
    logic [1:0]       cnt_next;

    assign push = en && tail_valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push && cnt_reg == 2'd1) begin
                slot0_reg <= tail_data;
            end else begin
                slot0_reg <= slot1_reg;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                slot0_reg <= tail_data;
            end else begin
                slot1_reg <= tail_data;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg;

    // checks

    `ATRS_ASSERT(a_stall_only_when_held, !s_tready |-> m_tvalid, "input stalled with no result held")

    `ATRS_ASSERT(a_pop_counts_down, (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1), "output buffer count did not drop after a transfer")

    `ATRS_ASSERT(a_quat_w_range, m_tvalid |-> ($signed(slot0_reg[223:192]) <= Q_ONE && $signed(slot0_reg[223:192]) >= -Q_ONE), "quaternion w out of range")

    `ATRS_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

// ----- hw/rtl/atrs_delay.sv -----
// fixed-length delay line that keeps side data in step with the pipeline
// uses atrs_pkg only by convention of the core
module atrs_delay
    import atrs_pkg::*;
#(
    parameter int unsigned W = 1,
    parameter int unsigned D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= din;
            for (int i = 1; i < int'(D); i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[D-1];

endmodule

// ----- hw/rtl/atrs_isqrt.sv -----
// pipelined floor square root of a 64 bit value, one result bit per stage
// depends on atrs_pkg for the stage count
module atrs_isqrt
    import atrs_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [31:0] dout
);

    logic [63:0] rem_reg  [SQRT_LAT];
    logic [63:0] root_reg [SQRT_LAT];

    for (genvar s = 0; s < int'(SQRT_LAT); s++) begin : g_step
        localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * s);
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] rem_next;
        logic [63:0] root_next;
        logic [64:0] trial;

        if (s == 0) begin : g_first
            assign rem_in  = din;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        always_comb begin
            trial = {1'b0, root_in} + {1'b0, BIT_VAL};
            if ({1'b0, rem_in} >= trial) begin
                rem_next  = rem_in - trial[63:0];
                root_next = (root_in >> 1) + BIT_VAL;
            end else begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign dout = root_reg[SQRT_LAT-1][31:0];

endmodule

// ----- hw/rtl/atrs_div.sv -----
// pipelined signed q30 divider: num * 2^30 / den, truncated and clamped to +-2^30
// depends on atrs_pkg for widths and the q2.30 one
module atrs_div
    import atrs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic [WORD_W-1:0]       quo
);

    localparam int unsigned NSTG = QUO_W + 1;

    logic [63:0]       rem_reg [NSTG];
    logic [QUO_W-1:0]  quo_reg [NSTG];
    logic [DEN_W-1:0]  den_reg [NSTG];
    logic              sat_reg [NSTG];
    logic              neg_reg [NSTG];
    logic              nil_reg [NSTG];
    logic [WORD_W-1:0] quo_out_reg;

    logic [NUM_W-1:0]  mag_next;
    logic              sat_next;

    always_comb begin
        mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        // quotient would need more than QUO_W bits, or divide by zero
        sat_next = (den == '0) || ({1'b0, mag_next} >= {1'b0, den, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {mag_next, 30'b0};
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            sat_reg[0] <= sat_next;
            neg_reg[0] <= num[NUM_W-1];
            nil_reg[0] <= (mag_next == '0);
        end
    end

    for (genvar s = 1; s < int'(NSTG); s++) begin : g_step
        localparam int unsigned B = QUO_W - s;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb begin
            trial = 64'(den_reg[s-1]) << B;
            if (rem_reg[s-1] >= trial) begin
                rem_next = rem_reg[s-1] - trial;
                quo_next = quo_reg[s-1] | (QUO_W'(1) << B);
            end else begin
                rem_next = rem_reg[s-1];
                quo_next = quo_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                den_reg[s] <= den_reg[s-1];
                sat_reg[s] <= sat_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                nil_reg[s] <= nil_reg[s-1];
            end
        end
    end

    logic [WORD_W-1:0] mag_q;

    always_comb begin
        if (nil_reg[NSTG-1]) begin
            mag_q = '0;
        end else if (sat_reg[NSTG-1] || ({1'b0, quo_reg[NSTG-1]} > Q_ONE)) begin
            mag_q = Q_ONE;
        end else begin
            mag_q = {1'b0, quo_reg[NSTG-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_out_reg <= neg_reg[NSTG-1] ? -mag_q : mag_q;
        end
    end

    assign quo = quo_out_reg;

endmodule

// ----- hw/rtl/atrs_lane.sv -----
// one column lane: length by sum of squares and square root, then the
// three normalised rotation entries; uses atrs_pkg, atrs_isqrt, atrs_div, atrs_delay
module atrs_lane
    import atrs_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  word_t     col_x,
    input  word_t     col_y,
    input  word_t     col_z,
    output lane_out_t lane_out
);

    logic [WORD_W-1:0] mag [3];
    logic [63:0]       sq_reg [3];
    logic [63:0]       sum_next;
    logic [63:0]       sum_reg;
    logic              zero_reg;
    logic [31:0]       len;
    logic [3*WORD_W-1:0] col_d;
    logic              zero_d;
    logic [SCALE_W-1:0] scale_next;
    logic [SCALE_W-1:0] scale_d;
    logic [WORD_W-1:0] r [3];

    assign mag[0] = col_x[WORD_W-1] ? WORD_W'(-col_x) : WORD_W'(col_x);
    assign mag[1] = col_y[WORD_W-1] ? WORD_W'(-col_y) : WORD_W'(col_y);
    assign mag[2] = col_z[WORD_W-1] ? WORD_W'(-col_z) : WORD_W'(col_z);

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 64'(mag[i]) * 64'(mag[i]);
            end
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
        end
    end

    atrs_isqrt u_len (
        .aclk (aclk),
        .en   (en),
        .din  (sum_reg),
        .dout (len)
    );

    atrs_delay #(.W(3 * WORD_W), .D(2 + SQRT_LAT)) u_col_dly (
        .aclk (aclk),
        .en   (en),
        .din  ({col_z, col_y, col_x}),
        .dout (col_d)
    );

    atrs_delay #(.W(1), .D(SQRT_LAT + DIV_LAT)) u_zero_dly (
        .aclk (aclk),
        .en   (en),
        .din  (zero_reg),
        .dout (zero_d)
    );

    // saturate the reported scale, the divisor keeps the full length
    assign scale_next = len[31] ? {SCALE_W{1'b1}} : len[SCALE_W-1:0];

    atrs_delay #(.W(SCALE_W), .D(DIV_LAT)) u_scale_dly (
        .aclk (aclk),
        .en   (en),
        .din  (scale_next),
        .dout (scale_d)
    );

    for (genvar j = 0; j < 3; j++) begin : g_div
        word_t comp;
        assign comp = $signed(col_d[j*WORD_W +: WORD_W]);
        atrs_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (NUM_W'(comp)),
            .den  ({1'b0, len}),
            .quo  (r[j])
        );
    end

    assign lane_out.zero  = zero_d;
    assign lane_out.scale = scale_d;
    assign lane_out.r0    = r[0];
    assign lane_out.r1    = r[1];
    assign lane_out.r2    = r[2];

endmodule

// ----- hw/rtl/atrs_merge.sv -----
// merging stage: trace and branch choice over the nine rotation entries,
// branch root and three quotients; uses atrs_pkg, atrs_isqrt, atrs_div, atrs_delay
module atrs_merge
    import atrs_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  lane_out_t lane_x,
    input  lane_out_t lane_y,
    input  lane_out_t lane_z,
    output quat_t     quat
);

    localparam logic signed [34:0] ONE35 = 35'sd1073741824;

    word_t r [9];
    logic signed [34:0] tr;

    assign r[0] = $signed(lane_x.r0);
    assign r[1] = $signed(lane_x.r1);
    assign r[2] = $signed(lane_x.r2);
    assign r[3] = $signed(lane_y.r0);
    assign r[4] = $signed(lane_y.r1);
    assign r[5] = $signed(lane_y.r2);
    assign r[6] = $signed(lane_z.r0);
    assign r[7] = $signed(lane_z.r1);
    assign r[8] = $signed(lane_z.r2);

    assign tr = 35'(r[0]) + 35'(r[4]) + 35'(r[8]);

    // stage a: comparisons, radicands and the six cross sums
    logic                    gt_tr_reg, gt_x_reg, gt_y_reg, zero_a_reg;
    logic signed [34:0]      rad_reg [4];
    logic signed [NUM_W-1:0] d57_reg, d62_reg, d13_reg, s31_reg, s62_reg, s75_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            gt_tr_reg  <= (tr > 35'sd0);
            gt_x_reg   <= (r[0] > r[4]) && (r[0] > r[8]);
            gt_y_reg   <= (r[4] > r[8]);
            zero_a_reg <= lane_x.zero || lane_y.zero || lane_z.zero;
            rad_reg[0] <= tr + ONE35;
            rad_reg[1] <= ONE35 + 35'(r[0]) - 35'(r[4]) - 35'(r[8]);
            rad_reg[2] <= ONE35 + 35'(r[4]) - 35'(r[0]) - 35'(r[8]);
            rad_reg[3] <= ONE35 + 35'(r[8]) - 35'(r[0]) - 35'(r[4]);
            d57_reg    <= NUM_W'(r[5]) - NUM_W'(r[7]);
            d62_reg    <= NUM_W'(r[6]) - NUM_W'(r[2]);
            d13_reg    <= NUM_W'(r[1]) - NUM_W'(r[3]);
            s31_reg    <= NUM_W'(r[3]) + NUM_W'(r[1]);
            s62_reg    <= NUM_W'(r[6]) + NUM_W'(r[2]);
            s75_reg    <= NUM_W'(r[7]) + NUM_W'(r[5]);
        end
    end

    // stage b: pick the branch, clamp its radicand, route numerators
    logic [1:0]              branch_next;
    logic signed [34:0]      rad_sel;
    logic signed [NUM_W-1:0] n_next [3];
    logic [63:0]             root_in_next;

    always_comb begin
        if (gt_tr_reg) begin
            branch_next = BR_W;
        end else if (gt_x_reg) begin
            branch_next = BR_X;
        end else if (gt_y_reg) begin
            branch_next = BR_Y;
        end else begin
            branch_next = BR_Z;
        end
        case (branch_next)
            BR_W: begin
                rad_sel = rad_reg[0];
                n_next[0] = d57_reg; n_next[1] = d62_reg; n_next[2] = d13_reg;
            end
            BR_X: begin
                rad_sel = rad_reg[1];
                n_next[0] = d57_reg; n_next[1] = s31_reg; n_next[2] = s62_reg;
            end
            BR_Y: begin
                rad_sel = rad_reg[2];
                n_next[0] = d62_reg; n_next[1] = s31_reg; n_next[2] = s75_reg;
            end
            default: begin
                rad_sel = rad_reg[3];
                n_next[0] = d13_reg; n_next[1] = s62_reg; n_next[2] = s75_reg;
            end
        endcase
        // non-orthonormal input can push the radicand negative
        if (rad_sel <= 35'sd0) begin
            root_in_next = '0;
        end else begin
            root_in_next = 64'(rad_sel[32:0]) << 30;
        end
    end

    logic [63:0]             root_in_reg;
    logic [1:0]              branch_b_reg;
    logic                    zero_b_reg;
    logic [3*NUM_W-1:0]      nums_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            root_in_reg  <= root_in_next;
            branch_b_reg <= branch_next;
            zero_b_reg   <= zero_a_reg;
            nums_reg     <= {n_next[2], n_next[1], n_next[0]};
        end
    end

    logic [31:0]        sq;
    logic [3*NUM_W-1:0] nums_d;
    logic [WORD_W-1:0]  diag_d;
    logic [1:0]         branch_d;
    logic               zero_d;
    logic [WORD_W-1:0]  q [3];

    atrs_isqrt u_root (
        .aclk (aclk),
        .en   (en),
        .din  (root_in_reg),
        .dout (sq)
    );

    atrs_delay #(.W(3 * NUM_W), .D(SQRT_LAT)) u_num_dly (
        .aclk (aclk),
        .en   (en),
        .din  (nums_reg),
        .dout (nums_d)
    );

    atrs_delay #(.W(WORD_W), .D(DIV_LAT)) u_diag_dly (
        .aclk (aclk),
        .en   (en),
        .din  ({1'b0, sq[31:1]}),
        .dout (diag_d)
    );

    atrs_delay #(.W(3), .D(SQRT_LAT + DIV_LAT)) u_ctl_dly (
        .aclk (aclk),
        .en   (en),
        .din  ({zero_b_reg, branch_b_reg}),
        .dout ({zero_d, branch_d})
    );

    for (genvar j = 0; j < 3; j++) begin : g_div
        atrs_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  ($signed(nums_d[j*NUM_W +: NUM_W])),
            .den  ({sq, 1'b0}),
            .quo  (q[j])
        );
    end

    // the three quotients fill w, x, y, z in order, skipping the diagonal one
    quat_t quat_next;
    quat_t quat_reg;

    always_comb begin
        if (zero_d) begin
            quat_next.x = '0;
            quat_next.y = '0;
            quat_next.z = '0;
            quat_next.w = Q_ONE;
        end else begin
            case (branch_d)
                BR_W: begin
                    quat_next.w = diag_d; quat_next.x = q[0];
                    quat_next.y = q[1];   quat_next.z = q[2];
                end
                BR_X: begin
                    quat_next.x = diag_d; quat_next.w = q[0];
                    quat_next.y = q[1];   quat_next.z = q[2];
                end
                BR_Y: begin
                    quat_next.y = diag_d; quat_next.w = q[0];
                    quat_next.x = q[1];   quat_next.z = q[2];
                end
                default: begin
                    quat_next.z = diag_d; quat_next.w = q[0];
                    quat_next.x = q[1];   quat_next.y = q[2];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule

// ----- dv/affine_matrix_to_trs_checker.sv -----
// result checker for the affine matrix to trs decomposition core
// depends on atrs_pkg; watches both stream channels and counts mismatches
module affine_matrix_to_trs_checker
    import atrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    localparam longint QONE = 64'sd1 << 30;

    logic [OUT_W-1:0] expected_q[$];

    assign pending = expected_q.size();

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // n * 2^30 / d toward zero, saturating at one
    function automatic longint ratio_q30(longint n, longint unsigned d);
        longint unsigned mag, quo;
        mag = (n < 0) ? longint'(-n) : n;
        if (mag == 0) return 0;
        if (d == 0) quo = QONE;
        else begin
            quo = (mag << 30) / d;
            if (quo > QONE) quo = QONE;
        end
        return (n < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint unsigned branch_root(longint a);
        if (a <= 0) return 0;
        return int_root(longint'(a) << 30);
    endfunction

    function automatic logic [OUT_W-1:0] decompose(logic [IN_W-1:0] din);
        longint c[9];
        longint r[9];
        longint q[4];
        longint unsigned len[3], ss, sq, k, m;
        logic is_zero;
        logic [OUT_W-1:0] res;
        longint tr;
        is_zero = 0;
        for (int i = 0; i < 9; i++) c[i] = longint'($signed(din[32*i +: 32]));
        for (int i = 0; i < 3; i++) begin
            ss = 0;
            for (int j = 0; j < 3; j++) begin
                m = (c[3*i+j] < 0) ? longint'(-c[3*i+j]) : c[3*i+j];
                ss += m * m;
            end
            len[i] = int_root(ss);
            if (ss == 0) is_zero = 1;
        end
        if (is_zero) begin
            q[0] = 0; q[1] = 0; q[2] = 0; q[3] = QONE;
        end else begin
            for (int i = 0; i < 9; i++) r[i] = ratio_q30(c[i], len[i/3]);
            tr = r[0] + r[4] + r[8];
            if (tr > 0) begin
                sq = branch_root(tr + QONE); k = sq * 2;
                q[3] = sq >> 1;
                q[0] = ratio_q30(r[5] - r[7], k);
                q[1] = ratio_q30(r[6] - r[2], k);
                q[2] = ratio_q30(r[1] - r[3], k);
            end else if (r[0] > r[4] && r[0] > r[8]) begin
                sq = branch_root(QONE + r[0] - r[4] - r[8]); k = sq * 2;
                q[3] = ratio_q30(r[5] - r[7], k);
                q[0] = sq >> 1;
                q[1] = ratio_q30(r[3] + r[1], k);
                q[2] = ratio_q30(r[6] + r[2], k);
            end else if (r[4] > r[8]) begin
                sq = branch_root(QONE + r[4] - r[0] - r[8]); k = sq * 2;
                q[3] = ratio_q30(r[6] - r[2], k);
                q[0] = ratio_q30(r[3] + r[1], k);
                q[1] = sq >> 1;
                q[2] = ratio_q30(r[7] + r[5], k);
            end else begin
                sq = branch_root(QONE + r[8] - r[0] - r[4]); k = sq * 2;
                q[3] = ratio_q30(r[1] - r[3], k);
                q[0] = ratio_q30(r[6] + r[2], k);
                q[1] = ratio_q30(r[7] + r[5], k);
                q[2] = sq >> 1;
            end
        end
        res = '0;
        res[95:0] = din[383:288];
        for (int i = 0; i < 4; i++) res[96 + 32*i +: 32] = q[i][31:0];
        for (int i = 0; i < 3; i++)
            res[224 + 31*i +: 31] = (len[i] > 64'h7fff_ffff) ? 31'h7fff_ffff : len[i][30:0];
        return res;
    endfunction

    function automatic string field_name(int idx);
        case (idx)
            0: return "out_move_x";
            1: return "out_move_y";
            2: return "out_move_z";
            3: return "quat_x";
            4: return "quat_y";
            5: return "quat_z";
            6: return "quat_w";
            7: return "scale_x";
            8: return "scale_y";
            default: return "scale_z";
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), decompose(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    for (int f = 0; f < 10; f++) begin
                        if (f < 7 && want[32*f +: 32] !== m_tdata[32*f +: 32]) begin
                            $error("%s: expected %h, got %h", field_name(f),
                                   want[32*f +: 32], m_tdata[32*f +: 32]);
                            errs++;
                        end
                        if (f >= 7 && want[224 + 31*(f-7) +: 31]
                                !== m_tdata[224 + 31*(f-7) +: 31]) begin
                            $error("%s: expected %h, got %h", field_name(f),
                                   want[224 + 31*(f-7) +: 31], m_tdata[224 + 31*(f-7) +: 31]);
                            errs++;
                        end
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- dv/affine_matrix_to_trs_core_tb.sv -----
// testbench top for the affine matrix to trs decomposition core
// depends on atrs_pkg, affine_matrix_to_trs_core and affine_matrix_to_trs_checker
module affine_matrix_to_trs_core_tb;
    import atrs_pkg::*;

    localparam int N_RANDOM  = 700;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = CORE_LAT + 50;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               calm = 0;    // no idling on either side in the last stretch

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    affine_matrix_to_trs_core dut (.*);

    affine_matrix_to_trs_checker u_checker (.*);

    // watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: bursts of stall, bursts of readiness
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            n = $urandom_range(1, 7);
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge aclk);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 8) == 0 ? 32'hffff_ffff : 32'h1;
            default: return $urandom();
        endcase
    endfunction

    // one transfer, then maybe a random gap
    task automatic send_matrix(logic [IN_W-1:0] m);
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        @(posedge aclk iff s_tready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // rotation about one axis by a random angle, scaled, with random translation
    function automatic logic [IN_W-1:0] rigid_matrix();
        real ang, s, c, sc[3];
        real col[9];
        int ax;
        logic [IN_W-1:0] m;
        ang = ($urandom_range(0, 62831) / 10000.0);
        s = $sin(ang);
        c = $cos(ang);
        ax = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) sc[i] = $urandom_range(1, 2000) / 100.0;
        for (int i = 0; i < 9; i++) col[i] = (i % 4 == 0) ? 1.0 : 0.0;
        case (ax)
            0: begin col[4] = c; col[5] = s; col[7] = -s; col[8] = c; end
            1: begin col[0] = c; col[2] = -s; col[6] = s; col[8] = c; end
            default: begin col[0] = c; col[1] = s; col[3] = -s; col[4] = c; end
        endcase
        for (int i = 0; i < 9; i++)
            m[32*i +: 32] = $rtoi(col[i] * sc[i/3] * 65536.0);
        for (int i = 9; i < 12; i++) m[32*i +: 32] = $urandom();
        return m;
    endfunction

    initial begin
        logic [IN_W-1:0] m;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, zero column, extremes, each branch, degenerate
        m = '0;
        m[31:0] = 32'h10000; m[159:128] = 32'h10000; m[287:256] = 32'h10000;
        send_matrix(m);
        m[159:128] = 0;                                    // zero column
        send_matrix(m);
        send_matrix('0);
        send_matrix({IN_W{1'b1}});
        for (int i = 0; i < 12; i++) m[32*i +: 32] = 32'h8000_0000;
        send_matrix(m);
        for (int i = 0; i < 12; i++) m[32*i +: 32] = 32'h7fff_ffff;
        send_matrix(m);
        // x, y and z dominant branches: rotate 180 degrees about each axis
        m = '0;
        m[31:0] = 32'h10000; m[159:128] = 32'hffff_0000; m[287:256] = 32'hffff_0000;
        send_matrix(m);
        m[31:0] = 32'hffff_0000; m[159:128] = 32'h10000; m[287:256] = 32'hffff_0000;
        send_matrix(m);
        m[31:0] = 32'hffff_0000; m[159:128] = 32'hffff_0000; m[287:256] = 32'h10000;
        send_matrix(m);
        // all columns equal
        for (int i = 0; i < 9; i++) m[32*i +: 32] = (i % 3 == 0) ? 32'h10000 : 32'h0;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[32*i +: 32] = 32'hffff_0000;
        send_matrix(m);
        for (int i = 0; i < 5; i++) send_matrix(rigid_matrix());

        // hold off until every expected result is back
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) calm = 1;
            if ($urandom_range(0, 3) != 0) m = rigid_matrix();
            else for (int i = 0; i < 12; i++) m[32*i +: 32] = rand_word();
            send_matrix(m);
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
